FILE: src/cfrd_pkg.sv
// ----------------------------------------------------------------------------
// cfrd_pkg
// Shared types and constants of the command FIFO register and drain unit.
// ----------------------------------------------------------------------------
package cfrd_pkg;

	localparam int ADDR_BITS_DEF = 26;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [7:0] OFF_STATUS  = 8'h00;
	localparam logic [7:0] OFF_CONTROL = 8'h02;
	localparam logic [7:0] OFF_CLEAR   = 8'h04;

	// offset[7:5] of the pointer word region (0x20 .. 0x3F)
	localparam logic [2:0] WORD_REGION = 3'b001;
	localparam logic [1:0] HALF_UPPER  = 2'b00;
	localparam logic [1:0] HALF_LOWER  = 2'b10;

	localparam int NUM_WORDS = 7;
	localparam logic [2:0] W_BASE = 3'd0;
	localparam logic [2:0] W_END  = 3'd1;
	localparam logic [2:0] W_HIGH = 3'd2;
	localparam logic [2:0] W_LOW  = 3'd3;
	localparam logic [2:0] W_DIST = 3'd4;
	localparam logic [2:0] W_WP   = 3'd5;
	localparam logic [2:0] W_RP   = 3'd6;
	localparam logic [2:0] W_NONE = 3'd7;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  reg_offset;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        fetch_valid;
		logic [25:0] fetch_address;
		logic        drain_busy;
	} result_t;

endpackage

FILE: src/cfrd_bank.sv
// ----------------------------------------------------------------------------
// cfrd_bank
// Register bank with access decode and drain pointer update. Computes the
// result of the item at its input and commits the new state on upd.
// ----------------------------------------------------------------------------
module cfrd_bank #(
	parameter int ADDR_BITS = cfrd_pkg::ADDR_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  cfrd_pkg::item_t   item,
	output cfrd_pkg::result_t result
);
	import cfrd_pkg::*;

	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);

	logic [15:0] status_q, control_q, clear_q;
	logic [15:0] status_d, control_d, clear_d;
	logic [31:0] words_q [NUM_WORDS];
	logic [31:0] words_d [NUM_WORDS];
	logic        armed_q, armed_d;

	logic [2:0]  widx;
	logic        in_words;
	logic [31:0] rp, wp, base, fend;
	logic [32:0] next_rp;

	assign widx     = item.reg_offset[4:2];
	assign in_words = (item.reg_offset[7:5] == WORD_REGION) && (widx != W_NONE);
	assign rp       = words_q[W_RP] & ADDR_MASK;
	assign wp       = words_q[W_WP] & ADDR_MASK;
	assign base     = words_q[W_BASE] & ADDR_MASK;
	assign fend     = words_q[W_END] & ADDR_MASK;
	assign next_rp  = {1'b0, rp} + 33'd1;

	always_comb begin
		status_d  = status_q;
		control_d = control_q;
		clear_d   = clear_q;
		words_d   = words_q;
		armed_d   = armed_q;
		result    = '0;
		unique case (item.action)
			ACT_READ: begin
				priority if (item.reg_offset == OFF_STATUS) begin
					result.read_data = status_q;
				end else if (item.reg_offset == OFF_CONTROL) begin
					result.read_data = control_q;
				end else if (in_words && item.reg_offset[1:0] == HALF_UPPER) begin
					result.read_data = words_q[widx][31:16];
				end else if (in_words && item.reg_offset[1:0] == HALF_LOWER) begin
					result.read_data = words_q[widx][15:0];
				end else begin
				end
			end
			ACT_WRITE: begin
				priority if (item.reg_offset == OFF_STATUS) begin
					status_d = item.write_data[15:0];
				end else if (item.reg_offset == OFF_CONTROL) begin
					control_d = item.write_data[15:0];
					armed_d   = 1'b1;
				end else if (item.reg_offset == OFF_CLEAR) begin
					clear_d = item.write_data[15:0];
				end else if (in_words && item.reg_offset[1:0] != 2'b11) begin
					if (item.reg_offset[1:0] == HALF_UPPER) begin
						if (|item.write_data[31:16]) begin
							words_d[widx] = item.write_data;
						end else begin
							words_d[widx][31:16] = item.write_data[15:0];
						end
					end else if (item.reg_offset[1:0] == HALF_LOWER) begin
						words_d[widx][15:0] = item.write_data[15:0];
					end
					if (widx == W_WP) begin
						armed_d = 1'b1;
					end
				end else begin
				end
			end
			ACT_TICK: begin
				if (armed_q) begin
					if (!control_q[0] || base == '0 || fend == '0 || rp == wp) begin
						armed_d = 1'b0;
					end else begin
						result.fetch_valid   = 1'b1;
						result.fetch_address = rp[25:0];
						// wrap to base at end
						if (next_rp >= {1'b0, fend}) begin
							words_d[W_RP] = base;
						end else begin
							words_d[W_RP] = next_rp[31:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
		result.drain_busy = armed_d && (((words_d[W_RP] ^ words_d[W_WP]) & ADDR_MASK) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= '0;
			control_q <= '0;
			clear_q   <= '0;
			armed_q   <= 1'b0;
			for (int i = 0; i < NUM_WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (upd) begin
			status_q  <= status_d;
			control_q <= control_d;
			clear_q   <= clear_d;
			armed_q   <= armed_d;
			words_q   <= words_d;
		end
	end

endmodule

FILE: src/command_fifo_register_drain_unit.sv
// ----------------------------------------------------------------------------
// command_fifo_register_drain_unit
// Command FIFO register block: 16-bit bus access to status, control, clear and
// the FIFO pointer words, and a byte drain that walks the read pointer.
// ----------------------------------------------------------------------------
// Each item is a register read, a register write or a drain tick and yields
// exactly one result. An item is registered on entry, decoded and applied to
// the register bank when it advances, and its result lands in an output
// register; one item is taken every cycle while the output is not stalled,
// with the single read-pointer increment and compare done between those two
// registers. A stalled result holds the item behind it in the input register;
// state changes only when an item moves to the output.
module command_fifo_register_drain_unit #(
	parameter int ADDR_BITS = cfrd_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  reg_offset,
	input  logic [31:0] write_data,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] read_data,
	output logic        fetch_valid,
	output logic [25:0] fetch_address,
	output logic        drain_busy
);
	import cfrd_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t res;
	logic    advance;

	assign advance    = valid_s1 && (!out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	cfrd_bank #(
		.ADDR_BITS(ADDR_BITS)
	) u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (advance),
		.item   (item_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{action: action, reg_offset: reg_offset, write_data: write_data};
		end
		if (advance) begin
			result_q <= res;
		end
	end

	assign result_valid  = out_valid_q;
	assign read_data     = result_q.read_data;
	assign fetch_valid   = result_q.fetch_valid;
	assign fetch_address = result_q.fetch_address;
	assign drain_busy    = result_q.drain_busy;

	// a fetch only comes from a drain tick
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.fetch_valid |-> item_s1.action == ACT_TICK)
		else $error("fetch from a non-tick item");

	// a fetch never carries read data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.fetch_valid |-> result_q.read_data == '0)
		else $error("fetch result with read data");

	// an advancing item always shows up at the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item lost");

	// the input stage never takes an item while holding a stalled one
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result_ready |=> valid_s1 && $stable(item_s1))
		else $error("held item overwritten");

endmodule
